[rtl/cca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_pkg
// shared types, codes and tables of the clock, calendar and alarm block
// ----------------------------------------------------------------------------
package cca_pkg;

	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int TENTH_W  = 4;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int YEAR_W   = 14;
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 4;

	// packed word layout: hour, minute, second, tenth, month, day, year
	localparam int FIELDS_W = HOUR_W + MINUTE_W + SECOND_W + TENTH_W + MONTH_W + DAY_W + YEAR_W;
	localparam int DATA_W   = ((FIELDS_W + 7) / 8) * 8;
	localparam int PAD_W    = DATA_W - FIELDS_W;

	// tenths added by one tick
	localparam int TICK_TENTHS = 1;

	localparam logic [YEAR_W-1:0] YEAR_MIN   = YEAR_W'(1900);
	localparam logic [YEAR_W-1:0] YEAR_MAX   = YEAR_W'(9999);
	localparam logic [YEAR_W-1:0] YEAR_RESET = YEAR_W'(1900);

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK        = 3'd0,
		ACT_SET_TIME    = 3'd1,
		ACT_SET_DATE    = 3'd2,
		ACT_SET_ALARM   = 3'd3,
		ACT_CLEAR_ALARM = 3'd4,
		ACT_READ_TIME   = 3'd5,
		ACT_READ_DATE   = 3'd6,
		ACT_NONE        = 3'd7
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_TIME        = 4'd0,
		ST_DATE        = 4'd1,
		ST_BAD_HOUR    = 4'd2,
		ST_BAD_MINUTE  = 4'd3,
		ST_BAD_SECOND  = 4'd4,
		ST_BAD_TENTH   = 4'd5,
		ST_BAD_MONTH   = 4'd6,
		ST_BAD_DAY     = 4'd7,
		ST_BAD_YEAR    = 4'd8,
		ST_ALARM_CLEAR = 4'd9,
		ST_ALARM_EXPIR = 4'd10
	} status_t;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic [TENTH_W-1:0]  tenth;
	} hms_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	// days per month, non-leap; codes outside 1..12 read as january
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:    len = DAY_W'(28);
			4'd4:    len = DAY_W'(30);
			4'd6:    len = DAY_W'(30);
			4'd9:    len = DAY_W'(30);
			4'd11:   len = DAY_W'(30);
			default: len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

[rtl/cca_hms_adv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_hms_adv
// adds a fixed number of tenths to a normalized time value, gives day carry
// ----------------------------------------------------------------------------
module cca_hms_adv
	import cca_pkg::*;
(
	input  hms_t cur,
	output hms_t nxt,
	output logic day_carry
);

	logic [TENTH_W:0] tenth_sum;
	logic             c_tenth;
	logic             c_second;
	logic             c_minute;

	always_comb begin
		tenth_sum = {1'b0, cur.tenth} + (TENTH_W + 1)'(TICK_TENTHS);
		c_tenth   = (tenth_sum >= (TENTH_W + 1)'(10));
		nxt.tenth = c_tenth ? TENTH_W'(tenth_sum - (TENTH_W + 1)'(10)) : tenth_sum[TENTH_W-1:0];

		c_second = c_tenth && (cur.second == SECOND_W'(59));
		if (c_second) begin
			nxt.second = '0;
		end else begin
			nxt.second = cur.second + SECOND_W'(c_tenth);
		end

		c_minute = c_second && (cur.minute == MINUTE_W'(59));
		if (c_minute) begin
			nxt.minute = '0;
		end else begin
			nxt.minute = cur.minute + MINUTE_W'(c_second);
		end

		day_carry = c_minute && (cur.hour == HOUR_W'(23));
		if (day_carry) begin
			nxt.hour = '0;
		end else begin
			nxt.hour = cur.hour + HOUR_W'(c_minute);
		end
	end

endmodule

[rtl/cca_date_next.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_date_next
// following calendar day, with the leap rule and the year wrap
// ----------------------------------------------------------------------------
module cca_date_next
	import cca_pkg::*;
(
	input  date_t cur,
	output date_t nxt
);

	localparam int RECIP   = 5243; // ceil(2^19 / 100), exact for 14-bit years
	localparam int RECIP_W = 13;
	localparam int PROD_W  = YEAR_W + RECIP_W;
	localparam int CENT_W  = 8;

	logic [PROD_W-1:0] prod;
	logic [CENT_W-1:0] century;
	logic [YEAR_W-1:0] century_x100;
	logic              div100;
	logic              leap;
	logic [DAY_W-1:0]  len;

	always_comb begin
		// year / 100 by reciprocal multiply
		prod         = PROD_W'(cur.year) * PROD_W'(RECIP);
		century      = prod[PROD_W-1:19];
		century_x100 = YEAR_W'(century) * YEAR_W'(100);
		div100       = (century_x100 == cur.year);
		// by 4 and not 100, or by 400 and not 3200
		leap = ((cur.year[1:0] == 2'd0) && !div100) ||
			(div100 && (century[1:0] == 2'd0) && (century[4:0] != 5'd0));

		len = month_len(cur.month);
		if ((cur.month == MONTH_W'(2)) && leap) begin
			len = len + DAY_W'(1);
		end

		nxt = cur;
		if (cur.day >= len) begin
			nxt.day = DAY_W'(1);
			if (cur.month >= MONTH_W'(12)) begin
				nxt.month = MONTH_W'(1);
				nxt.year  = (cur.year >= YEAR_MAX) ? '0 : cur.year + YEAR_W'(1);
			end else begin
				nxt.month = cur.month + MONTH_W'(1);
			end
		end else begin
			nxt.day = cur.day + DAY_W'(1);
		end
	end

endmodule

[rtl/clock_calendar_alarm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_calendar_alarm
// real-time clock and calendar with a relative alarm timer
// ----------------------------------------------------------------------------
// Each input word is one command (tick, set time, set date, set alarm, clear
// alarm, read time, read date), selected by s_axis_tuser. A tick advances the
// time of day by a fixed number of tenths and rolls the date at midnight,
// using the leap rule with the 3200-year exception and a year that wraps
// from 9999 to 0. While the alarm setting is nonzero an elapsed counter runs
// with the ticks; when it equals the setting an expiry word (status 10,
// carrying the setting) is sent and both clear. Set commands check their
// fields in order and report the first bad one; set date checks the day
// against the non-leap table. Ticks without expiry and unused action 7 give
// no output word. Throughput is one word per cycle while the output is not
// stalled: the clock, calendar and alarm registers are all updated as a
// command moves from the input register to the output register, which
// holds its result, and every command sees the state left by the one
// before it. Reset gives 00:00:00.0 on 1 January 1900 with the alarm off.
// ----------------------------------------------------------------------------
module clock_calendar_alarm
	import cca_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// hour, minute, second, tenth, month, day, year, zero pad
	input  logic [DATA_W-1:0]   s_axis_tdata,
	// action
	input  logic [ACTION_W-1:0] s_axis_tuser,

	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// out_hour, out_minute, out_second, out_tenth, out_month, out_day,
	// out_year, zero pad
	output logic [DATA_W-1:0]   m_axis_tdata,
	// status
	output logic [STATUS_W-1:0] m_axis_tuser
);

	// input register
	logic                valid_s1;
	action_t             action_s1;
	hms_t                time_s1;
	date_t               date_s1;
	logic                adv;

	// clock, calendar and alarm state
	hms_t                tod_q;
	date_t               cal_q;
	hms_t                alarm_q;
	hms_t                elapsed_q;

	hms_t                tod_n;
	date_t               cal_n;
	hms_t                alarm_n;
	hms_t                elapsed_n;

	// datapath helpers
	hms_t                tod_adv;
	logic                tod_carry;
	hms_t                el_adv;
	logic                el_carry_unused;
	date_t               cal_adv;
	logic                alarm_on;

	// result of the command in the input register
	logic                res_valid;
	status_t             res_status;
	hms_t                res_time;
	date_t               res_date;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	hms_t                out_time_q;
	date_t               out_date_q;

	// input stage moves when the output register is free or being drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= action_t'(s_axis_tuser);
			time_s1   <= '{hour:   s_axis_tdata[4:0],
				minute: s_axis_tdata[10:5],
				second: s_axis_tdata[16:11],
				tenth:  s_axis_tdata[20:17]};
			date_s1   <= '{month: s_axis_tdata[24:21],
				day:   s_axis_tdata[29:25],
				year:  s_axis_tdata[43:30]};
		end
	end

	cca_hms_adv u_tod_adv (
		.cur       (tod_q),
		.nxt       (tod_adv),
		.day_carry (tod_carry)
	);

	// elapsed counter only ever compared, its day carry goes nowhere
	cca_hms_adv u_elapsed_adv (
		.cur       (elapsed_q),
		.nxt       (el_adv),
		.day_carry (el_carry_unused)
	);

	cca_date_next u_date_next (
		.cur (cal_q),
		.nxt (cal_adv)
	);

	assign alarm_on = (alarm_q != '0);

	// command decode, checks and next state
	always_comb begin
		tod_n      = tod_q;
		cal_n      = cal_q;
		alarm_n    = alarm_q;
		elapsed_n  = elapsed_q;
		res_valid  = 1'b0;
		res_status = ST_TIME;
		res_time   = '0;
		res_date   = '0;

		case (action_s1)
			ACT_TICK: begin
				tod_n = tod_adv;
				if (tod_carry) begin
					cal_n = cal_adv;
				end
				if (alarm_on) begin
					elapsed_n = el_adv;
					if (el_adv == alarm_q) begin
						res_valid  = 1'b1;
						res_status = ST_ALARM_EXPIR;
						res_time   = alarm_q;
						alarm_n    = '0;
						elapsed_n  = '0;
					end
				end
			end
			ACT_SET_TIME, ACT_SET_ALARM: begin
				res_valid = 1'b1;
				if (time_s1.hour > HOUR_W'(23)) begin
					res_status = ST_BAD_HOUR;
				end else if (time_s1.minute > MINUTE_W'(59)) begin
					res_status = ST_BAD_MINUTE;
				end else if (time_s1.second > SECOND_W'(59)) begin
					res_status = ST_BAD_SECOND;
				end else if (time_s1.tenth > TENTH_W'(9)) begin
					res_status = ST_BAD_TENTH;
				end else begin
					res_status = ST_TIME;
					res_time   = time_s1;
					if (action_s1 == ACT_SET_TIME) begin
						tod_n = time_s1;
					end else begin
						// elapsed counter is left running
						alarm_n = time_s1;
					end
				end
			end
			ACT_SET_DATE: begin
				res_valid = 1'b1;
				if ((date_s1.month < MONTH_W'(1)) || (date_s1.month > MONTH_W'(12))) begin
					res_status = ST_BAD_MONTH;
				end else if ((date_s1.day < DAY_W'(1)) ||
					(date_s1.day > month_len(date_s1.month))) begin
					res_status = ST_BAD_DAY;
				end else if ((date_s1.year < YEAR_MIN) || (date_s1.year > YEAR_MAX)) begin
					res_status = ST_BAD_YEAR;
				end else begin
					res_status = ST_DATE;
					res_date   = date_s1;
					cal_n      = date_s1;
				end
			end
			ACT_CLEAR_ALARM: begin
				res_valid  = 1'b1;
				res_status = ST_ALARM_CLEAR;
				alarm_n    = '0;
			end
			ACT_READ_TIME: begin
				res_valid  = 1'b1;
				res_status = ST_TIME;
				res_time   = tod_q;
			end
			ACT_READ_DATE: begin
				res_valid  = 1'b1;
				res_status = ST_DATE;
				res_date   = cal_q;
			end
			default: begin
				// unused action: no word, no state change
				res_valid = 1'b0;
			end
		endcase
	end

	// state registers change only when a command leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tod_q     <= '0;
			cal_q     <= '{year: YEAR_RESET, month: MONTH_W'(1), day: DAY_W'(1)};
			alarm_q   <= '0;
			elapsed_q <= '0;
		end else if (adv) begin
			tod_q     <= tod_n;
			cal_q     <= cal_n;
			alarm_q   <= alarm_n;
			elapsed_q <= elapsed_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_status_q <= res_status;
			out_time_q   <= res_time;
			out_date_q   <= res_date;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_date_q.year, out_date_q.day, out_date_q.month,
		out_time_q.tenth, out_time_q.second, out_time_q.minute, out_time_q.hour};

endmodule

[dv/clock_calendar_alarm_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_calendar_alarm_tb
// self-checking bench for the clock, calendar and alarm block
// ----------------------------------------------------------------------------
// A table of hand-picked commands comes first: reset state, field limits,
// every rejection code, the year wrap, alarm expiry, alarm off and the
// ignored action. Random traffic follows, mostly well-formed sequences
// (alarm countdowns, month and year rollovers, time updates) mixed with
// noise. A local model of the clock tracks every accepted word and queues
// the word the block must return; each returned word is checked field by
// field in order. Both stream sides stall at random in changing proportions.
// ----------------------------------------------------------------------------
module clock_calendar_alarm_tb;
	import cca_pkg::*;

	localparam int ITEMS     = 2000;
	localparam int LIMIT     = 500000;
	localparam int DRAIN_MAX = 5000;
	localparam int DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	// years that exercise the leap rule, a zero entry draws a random year
	localparam int LEAP_PROBES [10] = '{1900, 1904, 2000, 2100, 2400, 3200, 6400,
		9600, 9999, 0};

	typedef enum logic [1:0] {
		CHK_MODEL,   // expectation comes from the clock model
		EXP_NONE,    // no word may come back
		EXP_WORD     // expectation typed into the table
	} row_kind_t;

	typedef struct packed {
		action_t             act;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic [TENTH_W-1:0]  tenth;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [YEAR_W-1:0]   year;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic [TENTH_W-1:0]  tenth;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [YEAR_W-1:0]   year;
	} word_t;

	typedef struct packed {
		cmd_t      cmd;
		row_kind_t kind;
		word_t     want;
	} row_t;

	// time of day or alarm / elapsed counter value
	typedef struct packed {
		logic [HOUR_W-1:0]   h;
		logic [MINUTE_W-1:0] m;
		logic [SECOND_W-1:0] s;
		logic [TENTH_W-1:0]  t;
	} tod_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [DATA_W-1:0]   s_axis_tdata  = '0;
	logic [ACTION_W-1:0] s_axis_tuser  = ACT_NONE;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [DATA_W-1:0]   m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	clock_calendar_alarm u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// model state
	tod_t               tod_now;
	tod_t               alarm_at;
	tod_t               elapsed;
	logic [DAY_W-1:0]   cal_d;
	logic [MONTH_W-1:0] cal_m;
	logic [YEAR_W-1:0]  cal_y;

	row_t  dir_table [$];
	cmd_t  cmd_queue [$];
	word_t due_words [$];

	int dir_idx     = 0;
	int items_sent  = 0;
	int words_seen  = 0;
	int expiries    = 0;
	int rejects     = 0;
	int mismatches  = 0;
	int tx_idle_pct = 23;
	int rx_idle_pct = 87;
	int cycle_count = 0;

	word_t              seen_word;
	word_t              due_word;
	logic [PAD_W-1:0]   seen_pad;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic cmd_t mk_cmd(action_t a, int h, int mi, int s, int t, int mo,
			int d, int y);
		cmd_t c;
		c.act    = a;
		c.hour   = HOUR_W'(h);
		c.minute = MINUTE_W'(mi);
		c.second = SECOND_W'(s);
		c.tenth  = TENTH_W'(t);
		c.month  = MONTH_W'(mo);
		c.day    = DAY_W'(d);
		c.year   = YEAR_W'(y);
		return c;
	endfunction

	// time-carrying word, date fields zero
	function automatic word_t tw(status_t st, int h, int mi, int s, int t);
		word_t w;
		w        = '0;
		w.status = st;
		w.hour   = HOUR_W'(h);
		w.minute = MINUTE_W'(mi);
		w.second = SECOND_W'(s);
		w.tenth  = TENTH_W'(t);
		return w;
	endfunction

	// date-carrying word, time fields zero
	function automatic word_t dw(status_t st, int mo, int d, int y);
		word_t w;
		w        = '0;
		w.status = st;
		w.month  = MONTH_W'(mo);
		w.day    = DAY_W'(d);
		w.year   = YEAR_W'(y);
		return w;
	endfunction

	function automatic void add_row(cmd_t c, row_kind_t k, word_t w);
		row_t r;
		r.cmd  = c;
		r.kind = k;
		r.want = w;
		dir_table.push_back(r);
	endfunction

	function automatic bit feb_has_29(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || ((y % 400 == 0) && (y % 3200 != 0));
	endfunction

	// add one tick worth of tenths, returns the carry out of hour 23
	function automatic bit bump(inout tod_t x);
		int t, s, m, h;
		t = int'(x.t) + TICK_TENTHS;
		s = int'(x.s) + t / 10;
		m = int'(x.m) + s / 60;
		h = int'(x.h) + m / 60;
		x.t = TENTH_W'(t % 10);
		x.s = SECOND_W'(s % 60);
		x.m = MINUTE_W'(m % 60);
		x.h = HOUR_W'(h % 24);
		return h >= 24;
	endfunction

	function automatic void roll_date();
		int len;
		len = DAYS[cal_m];
		if (cal_m == MONTH_W'(2) && feb_has_29(int'(cal_y)))
			len++;
		if (int'(cal_d) >= len) begin
			cal_d = DAY_W'(1);
			if (cal_m >= MONTH_W'(12)) begin
				cal_m = MONTH_W'(1);
				cal_y = YEAR_W'((int'(cal_y) + 1) % 10000);
			end else begin
				cal_m = cal_m + MONTH_W'(1);
			end
		end else begin
			cal_d = cal_d + DAY_W'(1);
		end
	endfunction

	// apply one command to the model, returns whether a word comes back
	function automatic bit predict_clock_word(input cmd_t c, output word_t w);
		tod_t v;
		bit   carry;
		bit   fired;
		w     = '0;
		fired = 1'b0;
		case (c.act)
			ACT_TICK: begin
				carry = bump(tod_now);
				if (alarm_at != '0) begin
					void'(bump(elapsed));
					if (elapsed == alarm_at) begin
						w        = tw(ST_ALARM_EXPIR, alarm_at.h, alarm_at.m, alarm_at.s,
							alarm_at.t);
						alarm_at = '0;
						elapsed  = '0;
						fired    = 1'b1;
					end
				end
				if (carry)
					roll_date();
				return fired;
			end
			ACT_SET_TIME, ACT_SET_ALARM: begin
				// first bad field wins, in hour, minute, second, tenth order
				if (c.hour > 23) begin
					w.status = ST_BAD_HOUR;
				end else if (c.minute > 59) begin
					w.status = ST_BAD_MINUTE;
				end else if (c.second > 59) begin
					w.status = ST_BAD_SECOND;
				end else if (c.tenth > 9) begin
					w.status = ST_BAD_TENTH;
				end else begin
					v.h = c.hour;
					v.m = c.minute;
					v.s = c.second;
					v.t = c.tenth;
					if (c.act == ACT_SET_TIME)
						tod_now = v;
					else
						alarm_at = v;
					w = tw(ST_TIME, v.h, v.m, v.s, v.t);
				end
				return 1'b1;
			end
			ACT_SET_DATE: begin
				// day limit is the non-leap table, so february 29 never passes
				if (c.month < 1 || c.month > 12) begin
					w.status = ST_BAD_MONTH;
				end else if (c.day < 1 || int'(c.day) > DAYS[c.month]) begin
					w.status = ST_BAD_DAY;
				end else if (c.year < 1900 || c.year > 9999) begin
					w.status = ST_BAD_YEAR;
				end else begin
					cal_m = c.month;
					cal_d = c.day;
					cal_y = c.year;
					w = dw(ST_DATE, cal_m, cal_d, cal_y);
				end
				return 1'b1;
			end
			ACT_CLEAR_ALARM: begin
				// elapsed counter keeps its value
				alarm_at = '0;
				w.status = ST_ALARM_CLEAR;
				return 1'b1;
			end
			ACT_READ_TIME: begin
				w = tw(ST_TIME, tod_now.h, tod_now.m, tod_now.s, tod_now.t);
				return 1'b1;
			end
			ACT_READ_DATE: begin
				w = dw(ST_DATE, cal_m, cal_d, cal_y);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic cmd_t noise_cmd();
		action_t a;
		a = action_t'($urandom_range(7));
		if ($urandom_range(1))
			return mk_cmd(a, $urandom_range(31), $urandom_range(63), $urandom_range(63),
				$urandom_range(15), $urandom_range(15), $urandom_range(31),
				$urandom_range(16383));
		return mk_cmd(a, $urandom_range(23), $urandom_range(59), $urandom_range(59),
			$urandom_range(9), $urandom_range(12, 1), $urandom_range(31, 1),
			$urandom_range(9999, 1900));
	endfunction

	// queue one random sequence, planned from the model state once the command queue is empty
	function automatic void plan_scenario();
		int   pick, k, n, mo, yr, i;
		bit   broken;
		tod_t target;
		pick = $urandom_range(99);
		if (pick < 30) begin
			// alarm countdown: set the alarm a few ticks past the running counter
			k      = $urandom_range(40, 1);
			target = elapsed;
			for (i = 0; i < k; i++)
				void'(bump(target));
			cmd_queue.push_back(mk_cmd(ACT_SET_ALARM, target.h, target.m, target.s,
				target.t, 0, 0, 0));
			broken = ($urandom_range(9) == 0);
			for (i = 0; i < k; i++) begin
				if (broken && i == k / 2)
					cmd_queue.push_back(mk_cmd(ACT_CLEAR_ALARM, 0, 0, 0, 0, 0, 0, 0));
				cmd_queue.push_back(mk_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
				if ($urandom_range(9) == 0)
					cmd_queue.push_back(mk_cmd(ACT_READ_TIME, 0, 0, 0, 0, 0, 0, 0));
			end
		end else if (pick < 55) begin
			// midnight at or near a month end, leap and wrap years favored
			mo = $urandom_range(12, 1);
			yr = LEAP_PROBES[$urandom_range(9)];
			if (yr == 0)
				yr = $urandom_range(9999, 1900);
			cmd_queue.push_back(mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, mo,
				DAYS[mo] - $urandom_range(1), yr));
			cmd_queue.push_back(mk_cmd(ACT_SET_TIME, 23, 59, 59, $urandom_range(9, 7),
				0, 0, 0));
			n = $urandom_range(4, 1);
			for (i = 0; i < n; i++) begin
				cmd_queue.push_back(mk_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
				if ($urandom_range(1))
					cmd_queue.push_back(mk_cmd(ACT_READ_DATE, 0, 0, 0, 0, 0, 0, 0));
			end
			cmd_queue.push_back(mk_cmd(ACT_READ_DATE, 0, 0, 0, 0, 0, 0, 0));
			cmd_queue.push_back(mk_cmd(ACT_READ_TIME, 0, 0, 0, 0, 0, 0, 0));
		end else if (pick < 75) begin
			cmd_queue.push_back(mk_cmd(ACT_SET_TIME, $urandom_range(23), $urandom_range(59),
				$urandom_range(59), $urandom_range(9), 0, 0, 0));
			n = $urandom_range(15, 1);
			for (i = 0; i < n; i++)
				cmd_queue.push_back(mk_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
			cmd_queue.push_back(mk_cmd(ACT_READ_TIME, 0, 0, 0, 0, 0, 0, 0));
		end else begin
			n = $urandom_range(8, 1);
			for (i = 0; i < n; i++)
				cmd_queue.push_back(noise_cmd());
		end
	endfunction

	// next word to send: table rows first, then random sequences
	function automatic bit next_command(output cmd_t c, output row_kind_t k, output word_t w);
		if (dir_idx < dir_table.size()) begin
			c = dir_table[dir_idx].cmd;
			k = dir_table[dir_idx].kind;
			w = dir_table[dir_idx].want;
			dir_idx++;
			return 1'b1;
		end
		k = CHK_MODEL;
		w = '0;
		if (cmd_queue.size() == 0 && items_sent < ITEMS)
			plan_scenario();
		if (cmd_queue.size() == 0) begin
			c = '0;
			return 1'b0;
		end
		c = cmd_queue.pop_front();
		return 1'b1;
	endfunction

	// sender side: directed table, random sequences, then drain and verdict
	initial begin : stimulus
		cmd_t      cur_cmd, nxt_cmd;
		row_kind_t cur_kind, nxt_kind;
		word_t     cur_want, nxt_want, model_word;
		bit        running, gives;
		int        waited;

		tod_now  = '0;
		alarm_at = '0;
		elapsed  = '0;
		cal_d    = DAY_W'(1);
		cal_m    = MONTH_W'(1);
		cal_y    = YEAR_RESET;
		cur_cmd  = '0;
		cur_kind = CHK_MODEL;
		cur_want = '0;

		// reset state, limits, year wrap
		add_row(mk_cmd(ACT_READ_TIME, 0, 0, 0, 0, 0, 0, 0), EXP_WORD, tw(ST_TIME, 0, 0, 0, 0));
		add_row(mk_cmd(ACT_READ_DATE, 0, 0, 0, 0, 0, 0, 0), EXP_WORD, dw(ST_DATE, 1, 1, 1900));
		add_row(mk_cmd(ACT_SET_TIME, 23, 59, 59, 9, 0, 0, 0), EXP_WORD,
			tw(ST_TIME, 23, 59, 59, 9));
		add_row(mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, 12, 31, 9999), EXP_WORD,
			dw(ST_DATE, 12, 31, 9999));
		// fields of a tick mean nothing
		add_row(mk_cmd(ACT_TICK, 31, 63, 63, 15, 15, 31, 16383), EXP_NONE, '0);
		add_row(mk_cmd(ACT_READ_DATE, 0, 0, 0, 0, 0, 0, 0), EXP_WORD, dw(ST_DATE, 1, 1, 0));
		// rejections, first bad field reported
		add_row(mk_cmd(ACT_SET_TIME, 31, 63, 63, 15, 0, 0, 0), EXP_WORD,
			tw(ST_BAD_HOUR, 0, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_TIME, 0, 60, 0, 0, 0, 0, 0), EXP_WORD,
			tw(ST_BAD_MINUTE, 0, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_TIME, 0, 0, 63, 15, 0, 0, 0), EXP_WORD,
			tw(ST_BAD_SECOND, 0, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_TIME, 23, 59, 59, 10, 0, 0, 0), EXP_WORD,
			tw(ST_BAD_TENTH, 0, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, 0, 0, 0), EXP_WORD, dw(ST_BAD_MONTH, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_DATE, 31, 63, 63, 15, 15, 31, 16383), EXP_WORD,
			dw(ST_BAD_MONTH, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, 2, 29, 2000), EXP_WORD,
			dw(ST_BAD_DAY, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, 1, 0, 2000), EXP_WORD,
			dw(ST_BAD_DAY, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, 1, 1, 1899), EXP_WORD,
			dw(ST_BAD_YEAR, 0, 0, 0));
		add_row(mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, 12, 31, 10000), EXP_WORD,
			dw(ST_BAD_YEAR, 0, 0, 0));
		// alarm two tenths out, counter still at zero
		add_row(mk_cmd(ACT_SET_ALARM, 0, 0, 0, 2, 0, 0, 0), EXP_WORD, tw(ST_TIME, 0, 0, 0, 2));
		add_row(mk_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0), EXP_NONE, '0);
		add_row(mk_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0), EXP_WORD,
			tw(ST_ALARM_EXPIR, 0, 0, 0, 2));
		add_row(mk_cmd(ACT_SET_ALARM, 0, 0, 1, 0, 0, 0, 0), EXP_WORD, tw(ST_TIME, 0, 0, 1, 0));
		add_row(mk_cmd(ACT_CLEAR_ALARM, 0, 0, 0, 0, 0, 0, 0), EXP_WORD,
			tw(ST_ALARM_CLEAR, 0, 0, 0, 0));
		// all-zero alarm means off
		add_row(mk_cmd(ACT_SET_ALARM, 0, 0, 0, 0, 0, 0, 0), EXP_WORD, tw(ST_TIME, 0, 0, 0, 0));
		add_row(mk_cmd(ACT_NONE, 31, 63, 63, 15, 15, 31, 16383), EXP_NONE, '0);
		// february 28 of a leap year rolls to the 29th
		add_row(mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, 2, 28, 2000), CHK_MODEL, '0);
		add_row(mk_cmd(ACT_SET_TIME, 23, 59, 59, 9, 0, 0, 0), CHK_MODEL, '0);
		add_row(mk_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0), CHK_MODEL, '0);
		add_row(mk_cmd(ACT_READ_DATE, 0, 0, 0, 0, 0, 0, 0), CHK_MODEL, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		running = 1'b1;
		while (running) begin
			@(posedge clk);
			if (s_axis_tvalid && s_axis_tready) begin
				gives = predict_clock_word(cur_cmd, model_word);
				case (cur_kind)
					CHK_MODEL: if (gives) due_words.push_back(model_word);
					EXP_WORD:  due_words.push_back(cur_want);
					default:   ;
				endcase
				if (cur_cmd.act != ACT_NONE)
					items_sent++;
				// idle mix: sender light then heavy, then no stalls at all
				if (items_sent >= 2 * ITEMS / 3) begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end else if (items_sent >= ITEMS / 3) begin
					tx_idle_pct = 87;
					rx_idle_pct = 23;
				end
			end
			// a word still waiting for tready holds its value
			if (!s_axis_tvalid || s_axis_tready) begin
				if ($urandom_range(99) < tx_idle_pct) begin
					s_axis_tvalid <= 1'b0;
				end else if (next_command(nxt_cmd, nxt_kind, nxt_want)) begin
					cur_cmd       = nxt_cmd;
					cur_kind      = nxt_kind;
					cur_want      = nxt_want;
					s_axis_tdata  <= {PAD_W'(0), nxt_cmd.year, nxt_cmd.day, nxt_cmd.month,
						nxt_cmd.tenth, nxt_cmd.second, nxt_cmd.minute, nxt_cmd.hour};
					s_axis_tuser  <= nxt_cmd.act;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
					running = 1'b0;
				end
			end
		end

		// let the last results come out, then wait for stray words
		for (waited = 0; waited < DRAIN_MAX && due_words.size() != 0; waited++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (due_words.size() != 0)
			flag_mismatch($sformatf("%0d expected words never arrived", due_words.size()));

		$display("run: %0d commands, %0d result words checked", items_sent, words_seen);
		$display("     %0d alarm expiries, %0d rejected settings, %0d mismatches",
			expiries, rejects, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver side: random tready, in-order check against the expected words
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_word.status = status_t'(m_axis_tuser);
			{seen_pad, seen_word.year, seen_word.day, seen_word.month, seen_word.tenth,
				seen_word.second, seen_word.minute, seen_word.hour} = m_axis_tdata;
			if (due_words.size() == 0) begin
				flag_mismatch($sformatf("word with status %0d but none expected",
					m_axis_tuser));
			end else begin
				due_word = due_words.pop_front();
				words_seen++;
				if (due_word.status == ST_ALARM_EXPIR)
					expiries++;
				if (due_word.status >= ST_BAD_HOUR && due_word.status <= ST_BAD_YEAR)
					rejects++;
				if (seen_word.status !== due_word.status)
					flag_mismatch($sformatf("status %0d, want %0d", m_axis_tuser,
						due_word.status));
				if (seen_word.hour !== due_word.hour)
					flag_mismatch($sformatf("hour %0d, want %0d", seen_word.hour,
						due_word.hour));
				if (seen_word.minute !== due_word.minute)
					flag_mismatch($sformatf("minute %0d, want %0d", seen_word.minute,
						due_word.minute));
				if (seen_word.second !== due_word.second)
					flag_mismatch($sformatf("second %0d, want %0d", seen_word.second,
						due_word.second));
				if (seen_word.tenth !== due_word.tenth)
					flag_mismatch($sformatf("tenth %0d, want %0d", seen_word.tenth,
						due_word.tenth));
				if (seen_word.month !== due_word.month)
					flag_mismatch($sformatf("month %0d, want %0d", seen_word.month,
						due_word.month));
				if (seen_word.day !== due_word.day)
					flag_mismatch($sformatf("day %0d, want %0d", seen_word.day,
						due_word.day));
				if (seen_word.year !== due_word.year)
					flag_mismatch($sformatf("year %0d, want %0d", seen_word.year,
						due_word.year));
			end
		end
	end

	// watchdog on total run length
	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words still expected", cycle_count,
			due_words.size());
		$display("simulation failed");
		$finish;
	end

endmodule
